>>> rtl/core/sidec_pkg.sv
`default_nettype none

package sidec_pkg;

    // fixed field widths
    localparam int VALUE_W = 64;
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [CHAR_W-1:0]  t_char;

    // width mode codes
    localparam t_mode MODE_8  = 2'd0;
    localparam t_mode MODE_16 = 2'd1;
    localparam t_mode MODE_32 = 2'd2;
    localparam t_mode MODE_64 = 2'd3;

    // ascii codes
    localparam t_char ASCII_ZERO  = 8'h30;
    localparam t_char ASCII_MINUS = 8'h2D;
    localparam t_char ASCII_NINE  = 8'h39;

    // double dabble correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    // converter to emitter control
    typedef struct packed {
        logic done;
        logic neg;
    } t_conv_ctl;

endpackage

`default_nettype wire

>>> rtl/core/sidec_if.sv
`default_nettype none

// input channel: raw value and width mode
interface sidec_in_if;
    logic                valid;
    logic                ready;
    sidec_pkg::t_value   value;
    sidec_pkg::t_mode    width_mode;

    modport source (output valid, output value, output width_mode, input ready);
    modport sink   (input valid, input value, input width_mode, output ready);
endinterface

// output channel: one character per transfer
interface sidec_out_if;
    logic                valid;
    logic                ready;
    sidec_pkg::t_char    character;
    logic                last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/signed_int_to_decimal_ascii_unit.sv
// Signed binary to decimal text converter.
// Input channel i_in carries a raw 64-bit value and a width mode (8, 16, 32
// or 64 bits, each capped at VALUE_BITS). The value is truncated to that
// width, sign extended, and its decimal text leaves on o_out one character
// per transfer, most significant first: '-' for a negative number, then the
// digits without leading zeros. The final character has last set.
// A front stage forms the sign and magnitude on the input transfer and puts
// them in a two-entry queue. The converter runs a double dabble unit that
// takes four magnitude bits a cycle, then the emitter sends one character a
// cycle while the receiver is ready. Reset clears the queue, the converter
// and the output register; no output is valid after reset. When the
// receiver stalls, the character on o_out holds, and the queue keeps taking
// input until it fills.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sidec_in_if.sink      i_in,
    sidec_out_if.source   o_out
);
    import sidec_pkg::*;

    localparam int VB   = (VALUE_BITS < 8) ? 8 : ((VALUE_BITS > 64) ? 64 : VALUE_BITS);
    localparam int NDIG = (VB * 30103) / 100000 + 1;

    logic          f_neg;
    logic [VB-1:0] f_mag;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic          q_neg;
    logic [VB-1:0] q_mag;
    t_conv_ctl     c_ctl;
    logic          e_ack;
    logic [3:0]    c_dig [NDIG];

    assign i_in.ready = !q_full;

    // front: sign and magnitude
    sidec_front #(.MAG_W(VB)) u_front (
        .i_value      (i_in.value),
        .i_width_mode (i_in.width_mode),
        .o_neg        (f_neg),
        .o_mag        (f_mag)
    );

    // decoupling queue
    sidec_queue #(.MAG_W(VB)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_neg   (f_neg),
        .i_mag   (f_mag),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_neg   (q_neg),
        .o_mag   (q_mag)
    );

    // back: binary to bcd
    sidec_conv #(.MAG_W(VB), .NDIG(NDIG)) u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_neg   (q_neg),
        .i_q_mag   (q_mag),
        .o_q_pop   (q_pop),
        .o_ctl     (c_ctl),
        .i_ack     (e_ack),
        .o_dig     (c_dig)
    );

    // back: character emitter
    sidec_emit #(.NDIG(NDIG)) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (c_ctl),
        .i_dig       (c_dig),
        .o_ack       (e_ack),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_character (o_out.character),
        .o_last      (o_out.last)
    );

endmodule

`default_nettype wire

>>> rtl/core/sidec_front.sv
`default_nettype none

module sidec_front #(
    parameter int MAG_W = 64
) (
    input  sidec_pkg::t_value   i_value,
    input  sidec_pkg::t_mode    i_width_mode,
    output logic                o_neg,
    output logic [MAG_W-1:0]    o_mag
);
    import sidec_pkg::*;

    localparam int W8  = (MAG_W < 8)  ? MAG_W : 8;
    localparam int W16 = (MAG_W < 16) ? MAG_W : 16;
    localparam int W32 = (MAG_W < 32) ? MAG_W : 32;
    localparam int W64 = MAG_W;

    logic [6:0]       ew;
    logic             sgn;
    logic [MAG_W-1:0] sx;

    // effective width and sign bit per mode
    always_comb begin
        case (i_width_mode)
            MODE_8: begin
                ew  = 7'(W8);
                sgn = i_value[W8-1];
            end
            MODE_16: begin
                ew  = 7'(W16);
                sgn = i_value[W16-1];
            end
            MODE_32: begin
                ew  = 7'(W32);
                sgn = i_value[W32-1];
            end
            default: begin
                ew  = 7'(W64);
                sgn = i_value[W64-1];
            end
        endcase
    end

    // truncate and sign extend
    always_comb begin
        for (int i = 0; i < MAG_W; i++) begin
            sx[i] = (i < int'(ew)) ? i_value[i] : sgn;
        end
    end

    // unsigned magnitude, most negative value included
    assign o_neg = sgn;
    assign o_mag = sgn ? (~sx + MAG_W'(1)) : sx;

endmodule

`default_nettype wire

>>> rtl/core/sidec_queue.sv
`default_nettype none

module sidec_queue #(
    parameter int MAG_W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_neg,
    input  logic [MAG_W-1:0]    i_mag,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_neg,
    output logic [MAG_W-1:0]    o_mag
);
    import sidec_pkg::*;

    logic [MAG_W:0] r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp;
    logic           n_rp;
    logic [1:0]     n_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_neg   = r_mem[r_rp][MAG_W];
    assign o_mag   = r_mem[r_rp][MAG_W-1:0];

    // pointer and fill count update
    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= {i_neg, i_mag};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sidec_conv.sv
`default_nettype none

module sidec_conv #(
    parameter int MAG_W = 64,
    parameter int NDIG  = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  logic                    i_q_neg,
    input  logic [MAG_W-1:0]        i_q_mag,
    output logic                    o_q_pop,
    output sidec_pkg::t_conv_ctl    o_ctl,
    input  logic                    i_ack,
    output logic [3:0]              o_dig [NDIG]
);
    import sidec_pkg::*;

    localparam int STEPS = (MAG_W + 3) / 4;
    localparam int PAD_W = STEPS * 4;
    localparam int BCD_W = NDIG * 4;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0] r_shift;
    logic [PAD_W-1:0] n_shift;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_bcd;
    logic [SW-1:0]    r_step;
    logic             r_busy;
    logic             r_done;
    logic             r_neg;

    assign o_q_pop   = i_q_valid && !r_busy && !r_done;
    assign o_ctl.done = r_done;
    assign o_ctl.neg  = r_neg;

    // four double dabble steps per cycle, msb of the magnitude first
    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        for (int b = 0; b < 4; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (n_bcd[4*d +: 4] >= BCD_ADJ_MIN) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + BCD_ADJ_ADD;
                end
            end
            n_bcd   = {n_bcd[BCD_W-2:0], n_shift[PAD_W-1]};
            n_shift = {n_shift[PAD_W-2:0], 1'b0};
        end
    end

    // control: load, iterate, hold result until the emitter takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + SW'(1);
            if (r_step == SW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ack) begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_shift <= PAD_W'(i_q_mag);
            r_bcd   <= '0;
            r_neg   <= i_q_neg;
        end else if (r_busy) begin
            r_shift <= n_shift;
            r_bcd   <= n_bcd;
        end
    end

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            o_dig[d] = r_bcd[4*d +: 4];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sidec_emit.sv
`default_nettype none

module sidec_emit #(
    parameter int NDIG = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sidec_pkg::t_conv_ctl    i_ctl,
    input  logic [3:0]              i_dig [NDIG],
    output logic                    o_ack,
    output logic                    o_valid,
    input  logic                    i_ready,
    output sidec_pkg::t_char        o_character,
    output logic                    o_last
);
    import sidec_pkg::*;

    localparam int CW = $clog2(NDIG + 1);
    localparam int IW = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [3:0]    r_dig [NDIG];
    logic [CW-1:0] r_cnt;
    logic          r_npend;
    logic          r_ovalid;
    t_char         r_char;
    logic          r_last;
    logic [CW-1:0] ld_cnt;
    logic [IW-1:0] sel;
    logic          empty;
    logic          adv;

    assign empty   = !r_npend && (r_cnt == '0);
    assign o_ack   = i_ctl.done && empty;
    assign adv     = !empty && (!r_ovalid || i_ready);
    assign sel     = IW'(r_cnt - CW'(1));

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // number of significant digits, zero gives one
    always_comb begin
        ld_cnt = CW'(1);
        for (int d = 0; d < NDIG; d++) begin
            if (i_dig[d] != 4'd0) begin
                ld_cnt = CW'(d + 1);
            end
        end
    end

    // control: load converted number, step down through the digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_npend  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_ack) begin
                r_cnt   <= ld_cnt;
                r_npend <= i_ctl.neg;
            end else if (adv) begin
                if (r_npend) begin
                    r_npend <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output register and digit store
    always_ff @(posedge i_clk) begin
        if (o_ack) begin
            r_dig <= i_dig;
        end
        if (adv) begin
            if (r_npend) begin
                r_char <= ASCII_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= ASCII_ZERO + t_char'(r_dig[sel]);
                r_last <= (r_cnt == CW'(1));
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sidec_chk.sv
`default_nettype none

module sidec_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  sidec_pkg::t_char   i_out_character,
    input  logic               i_out_last
);
    import sidec_pkg::*;

    // stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_character) && $stable(i_out_last))
        else $error("output changed while stalled");

    // only minus or digits leave the block
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_character == ASCII_MINUS) ||
            ((i_out_character >= ASCII_ZERO) && (i_out_character <= ASCII_NINE)))
        else $error("bad output character");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_character == ASCII_MINUS) |-> !i_out_last)
        else $error("minus flagged last");

    // an accepted minus sign is not directly followed by a second minus sign
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_character == ASCII_MINUS) |=>
            !(i_out_valid && (i_out_character == ASCII_MINUS)))
        else $error("two minus signs in a row");

    // nothing valid right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sidec_chk u_sidec_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);

`default_nettype wire
